// ----- src/bde_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the button debounce / encoder direction block
// no dependencies

package bde_pkg;

  localparam int NUM_PINS     = 4;
  localparam int HOLD_BITS    = 10;
  localparam int AGE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [HOLD_BITS-1:0] BUTTON_HOLD_RST  = 10'd100;
  localparam logic [HOLD_BITS-1:0] ENCODER_HOLD_RST = 10'd3;

  // pin indexes
  localparam logic [1:0] PIN_START = 2'd0;
  localparam logic [1:0] PIN_STOP  = 2'd1;
  localparam logic [1:0] PIN_ENC_A = 2'd2;
  localparam logic [1:0] PIN_ENC_B = 2'd3;

  // request modes
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_CHANGE = 1'b1;

  // event kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_ENCODER = 2'd2;

  // register indexes
  localparam logic REG_BUTTON_HOLD  = 1'b0;
  localparam logic REG_ENCODER_HOLD = 1'b1;

  // events decided for one tick, emitted by the back end in field order
  typedef struct packed {
    logic start_v;
    logic start_lvl;
    logic stop_v;
    logic stop_lvl;
    logic enc_v;
    logic enc_dir;
  } bde_rec_t;

endpackage

`default_nettype wire

// ----- src/bde_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// front end: pin state, age counters and per-tick event classification
// depends on bde_pkg

module bde_front #(
  parameter int AGE_BITS = bde_pkg::AGE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic                           mode,
  input  wire logic [1:0]                     pin_index,
  input  wire logic                           level,
  input  wire logic [bde_pkg::HOLD_BITS-1:0]  button_hold,
  input  wire logic [bde_pkg::HOLD_BITS-1:0]  encoder_hold,
  output logic                                push,
  output bde_pkg::bde_rec_t                   rec
);
  import bde_pkg::*;

  logic [AGE_BITS-1:0] age_r   [NUM_PINS];
  logic [AGE_BITS-1:0] age_inc [NUM_PINS];
  logic [NUM_PINS-1:0] pend_r;
  logic [NUM_PINS-1:0] lvl_r;
  logic [AGE_BITS-1:0] bhold_x;
  logic [AGE_BITS-1:0] ehold_x;
  logic                enc_fire;
  logic                tick;

  assign bhold_x = AGE_BITS'(button_hold);
  assign ehold_x = AGE_BITS'(encoder_hold);
  assign tick    = accept && (mode == MODE_TICK);

  // saturating increment
  always_comb begin
    for (int i = 0; i < NUM_PINS; i++) begin
      age_inc[i] = (age_r[i] == '1) ? age_r[i] : age_r[i] + AGE_BITS'(1);
    end
  end

  always_comb begin
    rec.start_v   = pend_r[PIN_START] && (age_inc[PIN_START] > bhold_x);
    rec.start_lvl = lvl_r[PIN_START];
    rec.stop_v    = pend_r[PIN_STOP] && (age_inc[PIN_STOP] > bhold_x);
    rec.stop_lvl  = lvl_r[PIN_STOP];
    enc_fire      = pend_r[PIN_ENC_A] && pend_r[PIN_ENC_B] &&
                    (age_inc[PIN_ENC_A] > ehold_x) && (age_inc[PIN_ENC_B] > ehold_x);
    rec.enc_v     = enc_fire && (lvl_r[PIN_ENC_A] != lvl_r[PIN_ENC_B]);
    rec.enc_dir   = age_inc[PIN_ENC_A] < age_inc[PIN_ENC_B];
    push          = tick && (rec.start_v || rec.stop_v || rec.enc_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      lvl_r  <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        age_r[i] <= '0;
      end
    end else if (accept) begin
      if (mode == MODE_CHANGE) begin
        lvl_r[pin_index]  <= level;
        pend_r[pin_index] <= 1'b1;
        age_r[pin_index]  <= '0;
      end else begin
        for (int i = 0; i < NUM_PINS; i++) begin
          age_r[i] <= age_inc[i];
        end
        if (rec.start_v) pend_r[PIN_START] <= 1'b0;
        if (rec.stop_v)  pend_r[PIN_STOP]  <= 1'b0;
        if (enc_fire) begin
          pend_r[PIN_ENC_A] <= 1'b0;
          pend_r[PIN_ENC_B] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/bde_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// short queue of tick event records between front and back end
// depends on bde_pkg

module bde_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  bde_pkg::bde_rec_t  push_rec,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output bde_pkg::bde_rec_t  head
);
  import bde_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  bde_rec_t            mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full      = (cnt_r == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_BITS'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/bde_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// back end: unpacks one event record into result items with an output register
// depends on bde_pkg

module bde_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  bde_pkg::bde_rec_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_kind,
  output logic               out_value,
  output logic               out_last
);
  import bde_pkg::*;

  bde_rec_t   rec_r, rec_nxt, rec_left;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       value_r, value_nxt;
  logic       last_r, last_nxt;
  logic       adv;
  logic       any;

  assign adv = !out_valid_r || out_ready;
  assign any = rec_r.start_v || rec_r.stop_v || rec_r.enc_v;

  always_comb begin
    rec_left      = rec_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (adv) begin
      out_valid_nxt = any;
      // emit in order start, stop, encoder; with nothing left the
      // encoder arm only loads don't-care data behind a low valid
      priority if (rec_r.start_v) begin
        kind_nxt         = KIND_START;
        value_nxt        = rec_r.start_lvl;
        rec_left.start_v = 1'b0;
      end else if (rec_r.stop_v) begin
        kind_nxt        = KIND_STOP;
        value_nxt       = rec_r.stop_lvl;
        rec_left.stop_v = 1'b0;
      end else begin
        kind_nxt       = KIND_ENCODER;
        value_nxt      = rec_r.enc_dir;
        rec_left.enc_v = 1'b0;
      end
      last_nxt = !(rec_left.start_v || rec_left.stop_v || rec_left.enc_v);
    end
    rec_nxt = rec_left;
    if (!(rec_left.start_v || rec_left.stop_v || rec_left.enc_v) && q_valid) begin
      rec_nxt = q_head;
      q_pop   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_r       <= rec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// ----- src/button_debounce_encoder_direction.sv -----
`timescale 1ns / 1ps
`default_nettype none
// top level of the button debounce and rotary encoder direction qualifier
// depends on bde_pkg, bde_front, bde_queue, bde_back

// Qualifies two buttons (start, stop) and two encoder lines (A, B). Each input
// request is either a millisecond tick or a level change on one pin. A change
// is absorbed and produces nothing. A tick ages all pins and may produce up
// to three result requests, in the order start, stop, encoder step, with tlast
// on the final one. The front end takes one request per cycle as long as its
// two-entry event queue has room; the back end drains one result per cycle
// through a registered output stage while the output is ready, so the
// sustained rate is bounded by the output side at one result per cycle. The
// first result of a tick passes through the event queue, the back end's record
// register and the output register. Hold times are set through the register
// port: offset 0x0 button hold (reset 100 ticks), offset 0x4 encoder hold
// (reset 3 ticks); a pin qualifies once its age exceeds the hold time.
// Registers are meant to be written while the block is idle.

module button_debounce_encoder_direction #(
  parameter int AGE_BITS = bde_pkg::AGE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [0] mode, [2:1] pin_index, [3] level, [7:4] zero
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [0] event_value, [7:1] zero
  output logic [1:0]       out_tuser,   // [1:0] event_kind
  output logic             out_tlast,
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bde_pkg::*;

  logic [HOLD_BITS-1:0] button_hold_r;
  logic [HOLD_BITS-1:0] encoder_hold_r;
  logic                 cfg_wr;
  logic                 in_accept;
  logic                 push;
  bde_rec_t             push_rec;
  logic                 q_full;
  logic                 q_valid;
  bde_rec_t             q_head;
  logic                 q_pop;
  logic                 out_value;

  // register port, one register per word
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_hold_r  <= BUTTON_HOLD_RST;
      encoder_hold_r <= ENCODER_HOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_BUTTON_HOLD:  button_hold_r  <= cfg_pwdata[HOLD_BITS-1:0];
        REG_ENCODER_HOLD: encoder_hold_r <= cfg_pwdata[HOLD_BITS-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_BUTTON_HOLD:  cfg_prdata = 32'(button_hold_r);
      REG_ENCODER_HOLD: cfg_prdata = 32'(encoder_hold_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // front end takes a request whenever the queue can hold a tick's events
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  bde_front #(
    .AGE_BITS(AGE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .mode         (in_tdata[0]),
    .pin_index    (in_tdata[2:1]),
    .level        (in_tdata[3]),
    .button_hold  (button_hold_r),
    .encoder_hold (encoder_hold_r),
    .push         (push),
    .rec          (push_rec)
  );

  bde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  bde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, out_value};

  // a pin change never yields events
  a_change_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tdata[0] == MODE_CHANGE)) |-> !push)
    else $error("pin change produced an event record");

  // events are only produced while the queue has room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("event queue overflow");

  // an encoder step is always the final result of its tick
  a_encoder_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_ENCODER)) |-> out_tlast)
    else $error("encoder step not marked last");

endmodule

`default_nettype wire
